// ===== src/multi_queue_ring_fifo_top_defines.svh =====
// Assertion macros for the multi-queue ring FIFO bank.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MULTI_QUEUE_RING_FIFO_TOP_DEFINES_SVH
`define MULTI_QUEUE_RING_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MQF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define MQF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mqf_pkg.sv =====
// Shared types and constants for the multi-queue ring FIFO bank.
// No dependencies.
package mqf_pkg;

    // Geometry of the bank
    localparam int DEPTH  = 64;
    localparam int QUEUES = 6;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int QID_W  = 3;
    localparam int VAL_W  = 31;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;

    // Derived widths
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int MEM_DEPTH = QUEUES * DEPTH;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Command codes
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_PUSH = 2'd0;
    localparam t_cmd CMD_POP  = 2'd1;
    localparam t_cmd CMD_FILL = 2'd2;

    // Status codes
    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_BADQ  = 2'd3;

endpackage

// ===== src/mqf_req_if.sv =====
// Request channel: valid/ready handshake carrying one queue command.
// Depends on mqf_pkg.
interface mqf_req_if import mqf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [QID_W-1:0]   queue_id;
    logic [VAL_W-1:0]   push_value;

    modport source (output valid, output command, output queue_id, output push_value,
                    input ready);
    modport sink   (input valid, input command, input queue_id, input push_value,
                    output ready);
endinterface

// ===== src/mqf_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one command result.
// Depends on mqf_pkg.
interface mqf_rsp_if import mqf_pkg::*;;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [VAL_W-1:0]   pop_value;
    logic [FILL_W-1:0]  fill_count;

    modport source (output valid, output status, output pop_value, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input pop_value, input fill_count,
                    output ready);
endinterface

// ===== src/mqf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mqf_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]                          i_wdata,
    input  logic                                        i_re,
    input  logic [((P_DEPTH > 1) ? $clog2(P_DEPTH) : 1)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]                          o_rdata
);
    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/multi_queue_ring_fifo_top.sv =====
// The result of a request is registered and appears in the cycle after its transfer.
// Throughput: one request per cycle while responses are taken; each request
// does at most one entry-store access and one pointer/count update on its own
// queue. A stalled response holds the request channel until the response is
// taken. Reset (synchronous, active low) clears pointers, counts and the
// output valid; the entry store is not cleared.
`include "multi_queue_ring_fifo_top_defines.svh"
module multi_queue_ring_fifo_top import mqf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqf_req_if.sink     i_req,
    mqf_rsp_if.source   o_rsp
);
    // Per-queue control state
    logic [PTR_W-1:0]  r_head  [QUEUES];
    logic [PTR_W-1:0]  r_tail  [QUEUES];
    logic [CNT_W-1:0]  r_count [QUEUES];

    // Output stage
    logic              r_out_valid;
    t_status           r_status;
    logic [FILL_W-1:0] r_fill;
    logic              r_pop;
    logic [VAL_W-1:0]  ram_rdata;

    // Request decode
    logic              req_xfer;
    logic              q_valid;
    logic [QSEL_W-1:0] qs;
    logic [CNT_W-1:0]  cur_cnt;
    logic [PTR_W-1:0]  cur_head;
    logic [PTR_W-1:0]  cur_tail;
    logic              do_push;
    logic              do_pop;
    t_status           n_status;
    logic [CNT_W-1:0]  n_count;
    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic [ADDR_W-1:0] base_addr;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign req_xfer    = i_req.valid && i_req.ready;
    assign q_valid     = 32'(i_req.queue_id) < QUEUES;
    assign qs          = QSEL_W'(i_req.queue_id);
    assign cur_cnt     = r_count[qs];
    assign cur_head    = r_head[qs];
    assign cur_tail    = r_tail[qs];
    assign base_addr   = ADDR_W'(32'(qs) * DEPTH);

    // Command evaluation against the selected queue
    always_comb begin
        n_status = ST_OK;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        if (!q_valid) begin
            n_status = ST_BADQ;
        end else begin
            case (i_req.command)
                CMD_PUSH: begin
                    if (32'(cur_cnt) == DEPTH) n_status = ST_FULL;
                    else                       do_push  = req_xfer;
                end
                CMD_POP: begin
                    if (cur_cnt == '0) n_status = ST_EMPTY;
                    else               do_pop   = req_xfer;
                end
                default: ;  // fill-count read and unused code: no change
            endcase
        end
    end

    // Next pointer and count values, with wrap at the last entry
    always_comb begin
        n_head  = (32'(cur_head) == DEPTH - 1) ? '0 : PTR_W'(cur_head + 1'b1);
        n_tail  = (32'(cur_tail) == DEPTH - 1) ? '0 : PTR_W'(cur_tail + 1'b1);
        n_count = cur_cnt;
        if (do_push)     n_count = CNT_W'(cur_cnt + 1'b1);
        else if (do_pop) n_count = CNT_W'(cur_cnt - 1'b1);
    end

    // Pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (do_push) begin
                r_tail[qs]  <= n_tail;
                r_count[qs] <= n_count;
            end
            if (do_pop) begin
                r_head[qs]  <= n_head;
                r_count[qs] <= n_count;
            end
        end
    end

    // Entry store: push writes at the tail, pop reads at the head
    mqf_ram #(
        .P_WIDTH (VAL_W),
        .P_DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (ADDR_W'(base_addr + ADDR_W'(cur_tail))),
        .i_wdata (i_req.push_value),
        .i_re    (do_pop),
        .i_raddr (ADDR_W'(base_addr + ADDR_W'(cur_head))),
        .o_rdata (ram_rdata)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (req_xfer)         r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
        if (req_xfer) begin
            r_status <= n_status;
            r_pop    <= do_pop;
            r_fill   <= q_valid ? FILL_W'(n_count) : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.pop_value  = r_pop ? ram_rdata : '0;
    assign o_rsp.fill_count = r_fill;

    // Checks; read data only matters once a pop has loaded it
    `MQF_ASSERT_NEXT(a_pop_data_holds, r_out_valid && !o_rsp.ready,
        $stable(r_pop) && (!r_pop || $stable(ram_rdata)), "popped value changed during stall")
    `MQF_ASSERT_NOW(a_full_fill, r_out_valid && r_status == ST_FULL,
        r_fill == FILL_W'(DEPTH), "full status without full count")
    `MQF_ASSERT_NOW(a_empty_clean, r_out_valid && r_status == ST_EMPTY,
        r_fill == '0 && !r_pop, "empty status with data or count")
endmodule
